// File: rtl/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared constants for the midpoint line rasterizer: default coordinate
// width, colour width and request codes.
// ----------------------------------------------------------------------------
package mlr_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int COLOR_BITS     = 24;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

endpackage

// File: rtl/mlr_setup.sv
// ----------------------------------------------------------------------------
// mlr_setup
// Octant mapping for a new line: signs of the deltas, steep flag and the
// major and minor axis lengths.
// ----------------------------------------------------------------------------
module mlr_setup import mlr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_end,
	output logic                  x_negative,
	output logic                  y_negative,
	output logic                  steep,
	output logic [COORD_BITS-1:0] major_len,
	output logic [COORD_BITS-1:0] minor_len
);

	logic [COORD_BITS-1:0] adx;
	logic [COORD_BITS-1:0] ady;

	always_comb begin
		x_negative = x_end < x_start;
		y_negative = y_end < y_start;
		adx        = x_negative ? (x_start - x_end) : (x_end - x_start);
		ady        = y_negative ? (y_start - y_end) : (y_end - y_start);
		steep      = ady > adx;
		major_len  = steep ? ady : adx;
		minor_len  = steep ? adx : ady;
	end

endmodule

// File: rtl/mlr_core.sv
// ----------------------------------------------------------------------------
// mlr_core
// Line state, midpoint decision step, mapping back to screen space and the
// result register.
// ----------------------------------------------------------------------------
module mlr_core import mlr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic                  req_type,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COLOR_BITS-1:0] color,
	input  logic                  set_x_negative,
	input  logic                  set_y_negative,
	input  logic                  set_steep,
	input  logic [COORD_BITS-1:0] set_major_len,
	input  logic [COORD_BITS-1:0] set_minor_len,
	output logic                  room,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [COLOR_BITS-1:0] pixel_color,
	output logic                  last
);

	localparam int DW = COORD_BITS + 3;
	localparam int IW = COORD_BITS + 2;

	logic                  active_q;
	logic signed [DW-1:0]  decision_q;
	logic signed [IW-1:0]  inc_straight_q;
	logic signed [IW-1:0]  inc_diagonal_q;
	logic [COORD_BITS-1:0] major_count_q;
	logic [COORD_BITS-1:0] minor_count_q;
	logic [COORD_BITS-1:0] major_length_q;
	logic                  steep_q;
	logic                  x_negative_q;
	logic                  y_negative_q;
	logic [COORD_BITS-1:0] origin_x_q;
	logic [COORD_BITS-1:0] origin_y_q;
	logic [COLOR_BITS-1:0] line_color_q;
	logic                  out_valid_q;

	logic                  is_start;
	logic                  is_step;
	logic                  diag;
	logic signed [DW-1:0]  decision_nx;
	logic [COORD_BITS-1:0] major_nx;
	logic [COORD_BITS-1:0] minor_nx;
	logic [COORD_BITS-1:0] dx_abs;
	logic [COORD_BITS-1:0] dy_abs;
	logic [COORD_BITS-1:0] step_x;
	logic [COORD_BITS-1:0] step_y;
	logic                  step_last;

	function automatic logic [COORD_BITS-1:0] offset_coord(
		input logic [COORD_BITS-1:0] base,
		input logic [COORD_BITS-1:0] delta,
		input logic                  negative
	);
		return negative ? (base - delta) : (base + delta);
	endfunction

	always_comb begin
		is_start    = go && (req_type == REQ_START);
		is_step     = go && (req_type == REQ_STEP) && active_q;
		diag        = decision_q > 0;
		decision_nx = decision_q + (diag ? {inc_diagonal_q[IW-1], inc_diagonal_q}
		                                 : {inc_straight_q[IW-1], inc_straight_q});
		major_nx    = major_count_q + 1'b1;
		minor_nx    = diag ? (minor_count_q + 1'b1) : minor_count_q;
		dx_abs      = steep_q ? minor_nx : major_nx;
		dy_abs      = steep_q ? major_nx : minor_nx;
		step_x      = offset_coord(origin_x_q, dx_abs, x_negative_q);
		step_y      = offset_coord(origin_y_q, dy_abs, y_negative_q);
		step_last   = major_nx >= major_length_q;
		room        = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q       <= 1'b0;
			decision_q     <= '0;
			inc_straight_q <= '0;
			inc_diagonal_q <= '0;
			major_count_q  <= '0;
			minor_count_q  <= '0;
			major_length_q <= '0;
			steep_q        <= 1'b0;
			x_negative_q   <= 1'b0;
			y_negative_q   <= 1'b0;
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			line_color_q   <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (is_start) begin
				active_q       <= set_major_len != '0;
				decision_q     <= $signed({2'b00, set_minor_len, 1'b0})
				                  - $signed({3'b000, set_major_len});
				inc_straight_q <= $signed({1'b0, set_minor_len, 1'b0});
				inc_diagonal_q <= $signed({1'b0, set_minor_len, 1'b0})
				                  - $signed({1'b0, set_major_len, 1'b0});
				major_count_q  <= '0;
				minor_count_q  <= '0;
				major_length_q <= set_major_len;
				steep_q        <= set_steep;
				x_negative_q   <= set_x_negative;
				y_negative_q   <= set_y_negative;
				origin_x_q     <= x_start;
				origin_y_q     <= y_start;
				line_color_q   <= color;
			end else if (is_step) begin
				decision_q    <= decision_nx;
				major_count_q <= major_nx;
				minor_count_q <= minor_nx;
				if (step_last) begin
					active_q <= 1'b0;
				end
			end
			if (is_start || is_step) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_start) begin
			pixel_x     <= x_start;
			pixel_y     <= y_start;
			pixel_color <= color;
			last        <= set_major_len == '0;
		end else if (is_step) begin
			pixel_x     <= step_x;
			pixel_y     <= step_y;
			pixel_color <= line_color_q;
			last        <= step_last;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_count_below_length: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> major_count_q < major_length_q)
		else $error("major count reached the length on an active line");

	a_idle_count_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> major_count_q == major_length_q)
		else $error("idle with the major count short of the length");

	a_minor_not_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		minor_count_q <= major_count_q)
		else $error("minor count ahead of the major count");

	a_step_emits: assert property (@(posedge clk) disable iff (!arst_n)
		is_step |=> out_valid_q && (pixel_color == $past(line_color_q)))
		else $error("step on an active line gave no pixel");
`endif

endmodule

// File: rtl/midpoint_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_unit
// All-octant midpoint line rasterizer with an input register and a result
// register.
// ----------------------------------------------------------------------------
// A start transaction (req_type 0) gives both endpoints and a colour and
// yields the start pixel; each step transaction (req_type 1) yields the next
// pixel, and the end point carries last. A step with no line in progress is
// taken and yields nothing. One transaction is taken every cycle while the
// output is not stalled; its pixel passes the input register and then the
// result register. The pace is set by the single decision add and compare
// per pixel.
module midpoint_line_rasterizer_unit import mlr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  req_type,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_end,
	input  logic [COLOR_BITS-1:0] color,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [COLOR_BITS-1:0] pixel_color,
	output logic                  last
);

	logic                  valid_s1;
	logic                  req_type_s1;
	logic [COORD_BITS-1:0] x_start_s1;
	logic [COORD_BITS-1:0] y_start_s1;
	logic [COORD_BITS-1:0] x_end_s1;
	logic [COORD_BITS-1:0] y_end_s1;
	logic [COLOR_BITS-1:0] color_s1;

	logic                  room;
	logic                  go;
	logic                  set_x_negative;
	logic                  set_y_negative;
	logic                  set_steep;
	logic [COORD_BITS-1:0] set_major_len;
	logic [COORD_BITS-1:0] set_minor_len;

	assign go       = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_type_s1 <= req_type;
			x_start_s1  <= x_start;
			y_start_s1  <= y_start;
			x_end_s1    <= x_end;
			y_end_s1    <= y_end;
			color_s1    <= color;
		end
	end

	mlr_setup #(
		.COORD_BITS(COORD_BITS)
	) u_setup (
		.x_start    (x_start_s1),
		.y_start    (y_start_s1),
		.x_end      (x_end_s1),
		.y_end      (y_end_s1),
		.x_negative (set_x_negative),
		.y_negative (set_y_negative),
		.steep      (set_steep),
		.major_len  (set_major_len),
		.minor_len  (set_minor_len)
	);

	mlr_core #(
		.COORD_BITS(COORD_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.go             (go),
		.req_type       (req_type_s1),
		.x_start        (x_start_s1),
		.y_start        (y_start_s1),
		.color          (color_s1),
		.set_x_negative (set_x_negative),
		.set_y_negative (set_y_negative),
		.set_steep      (set_steep),
		.set_major_len  (set_major_len),
		.set_minor_len  (set_minor_len),
		.room           (room),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.pixel_color    (pixel_color),
		.last           (last)
	);

endmodule

// File: verif/mlr_pixel_checker.sv
// ----------------------------------------------------------------------------
// mlr_pixel_checker
// Watches both channels of the midpoint line rasterizer, predicts each pixel
// from the accepted transactions and compares the pixels that come out.
// ----------------------------------------------------------------------------
module mlr_pixel_checker import mlr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic                  req_type,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_end,
	input  logic [COLOR_BITS-1:0] color,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	input  logic [COLOR_BITS-1:0] pixel_color,
	input  logic                  last,
	output int                    errors,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DW = COORD_BITS + 3;
	localparam int IW = COORD_BITS + 2;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COLOR_BITS-1:0] c;
		logic                  is_last;
	} pixel_t;

	pixel_t expected_pixels[$];
	int     mismatch_count = 0;
	int     waiting_count  = 0;

	logic                  line_busy;
	logic signed [DW-1:0]  decision;
	logic        [IW-1:0]  inc_straight;
	logic signed [IW-1:0]  inc_diagonal;
	logic [COORD_BITS-1:0] major_cnt;
	logic [COORD_BITS-1:0] minor_cnt;
	logic [COORD_BITS-1:0] major_len;
	logic                  is_steep;
	logic                  x_neg;
	logic                  y_neg;
	logic [COORD_BITS-1:0] org_x;
	logic [COORD_BITS-1:0] org_y;
	logic [COLOR_BITS-1:0] line_col;

	assign errors  = mismatch_count;
	assign pending = waiting_count;

	function automatic pixel_t screen_pixel(input logic is_last);
		logic [COORD_BITS-1:0] dx;
		logic [COORD_BITS-1:0] dy;
		pixel_t                px;
		dx         = is_steep ? minor_cnt : major_cnt;
		dy         = is_steep ? major_cnt : minor_cnt;
		px.x       = x_neg ? org_x - dx : org_x + dx;
		px.y       = y_neg ? org_y - dy : org_y + dy;
		px.c       = line_col;
		px.is_last = is_last;
		return px;
	endfunction

	task automatic rasterize_item();
		logic [COORD_BITS-1:0] adx;
		logic [COORD_BITS-1:0] ady;
		logic [COORD_BITS-1:0] maj;
		logic [COORD_BITS-1:0] mnr;
		logic                  at_end;
		if (req_type == REQ_START) begin
			x_neg        = x_end < x_start;
			y_neg        = y_end < y_start;
			adx          = x_neg ? x_start - x_end : x_end - x_start;
			ady          = y_neg ? y_start - y_end : y_end - y_start;
			is_steep     = ady > adx;
			maj          = is_steep ? ady : adx;
			mnr          = is_steep ? adx : ady;
			org_x        = x_start;
			org_y        = y_start;
			line_col     = color;
			major_len    = maj;
			major_cnt    = '0;
			minor_cnt    = '0;
			decision     = DW'(mnr) * 2 - DW'(maj);
			inc_straight = IW'(mnr) * 2;
			inc_diagonal = (IW'(mnr) - IW'(maj)) * 2;
			line_busy    = maj != '0;
			expected_pixels.push_back(screen_pixel(maj == '0));
		end else if (line_busy) begin
			if (decision > 0) begin
				decision  = decision + DW'(inc_diagonal);
				minor_cnt = minor_cnt + 1'b1;
			end else begin
				decision = decision + DW'(inc_straight);
			end
			major_cnt = major_cnt + 1'b1;
			at_end    = major_cnt >= major_len;
			if (at_end) begin
				line_busy = 1'b0;
			end
			expected_pixels.push_back(screen_pixel(at_end));
		end
	endtask

	task automatic check_pixel();
		pixel_t want;
		if (expected_pixels.size() == 0) begin
			$error("unexpected pixel at (%0d, %0d)", pixel_x, pixel_y);
			mismatch_count++;
		end else begin
			want = expected_pixels.pop_front();
			if (pixel_x !== want.x) begin
				$error("pixel_x: expected %0d, got %0d", want.x, pixel_x);
				mismatch_count++;
			end
			if (pixel_y !== want.y) begin
				$error("pixel_y: expected %0d, got %0d", want.y, pixel_y);
				mismatch_count++;
			end
			if (pixel_color !== want.c) begin
				$error("pixel_color: expected %06h, got %06h", want.c, pixel_color);
				mismatch_count++;
			end
			if (last !== want.is_last) begin
				$error("last: expected %0d, got %0d", want.is_last, last);
				mismatch_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_busy    = 1'b0;
			decision     = '0;
			inc_straight = '0;
			inc_diagonal = '0;
			major_cnt    = '0;
			minor_cnt    = '0;
			major_len    = '0;
			is_steep     = 1'b0;
			x_neg        = 1'b0;
			y_neg        = 1'b0;
			org_x        = '0;
			org_y        = '0;
			line_col     = '0;
			expected_pixels.delete();
		end else begin
			if (out_valid && !out_stall) begin
				check_pixel();
			end
			if (in_valid && !in_stall) begin
				rasterize_item();
			end
		end
		waiting_count = expected_pixels.size();
	end

endmodule

// File: verif/tb_midpoint_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// tb_midpoint_line_rasterizer_unit
// Drives start and step transactions into the line rasterizer with random
// gaps and output stalls, including one long hold-off, and reports the
// verdict from the pixel checker.
// ----------------------------------------------------------------------------
module tb_midpoint_line_rasterizer_unit import mlr_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB         = COORD_BITS_DEF;
	localparam int CMAX       = (1 << CB) - 1;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_LEN   = 300;

	logic                  clk;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic                  req_type    = REQ_START;
	logic [CB-1:0]         x_start     = '0;
	logic [CB-1:0]         y_start     = '0;
	logic [CB-1:0]         x_end       = '0;
	logic [CB-1:0]         y_end       = '0;
	logic [COLOR_BITS-1:0] color       = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [CB-1:0]         pixel_x;
	logic [CB-1:0]         pixel_y;
	logic [COLOR_BITS-1:0] pixel_color;
	logic                  last;

	int   errors;
	int   pending;
	int   line_items   = 0;
	int   idle_cycles  = 0;
	logic calm         = 1'b0;
	logic hold_req     = 1'b0;
	logic hold_issued  = 1'b0;

	midpoint_line_rasterizer_unit #(
		.COORD_BITS(CB)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.x_start(x_start),
		.y_start(y_start),
		.x_end(x_end),
		.y_end(y_end),
		.color(color),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.pixel_color(pixel_color),
		.last(last)
	);

	mlr_pixel_checker #(
		.COORD_BITS(CB)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.x_start(x_start),
		.y_start(y_start),
		.x_end(x_end),
		.y_end(y_end),
		.color(color),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.pixel_color(pixel_color),
		.last(last),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic offer(input logic req, input int xs, input int ys, input int xe,
			input int ye, input logic [COLOR_BITS-1:0] col);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type <= req;
		x_start  <= CB'(xs);
		y_start  <= CB'(ys);
		x_end    <= CB'(xe);
		y_end    <= CB'(ye);
		color    <= col;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic step_line(input int n);
		repeat (n) begin
			offer(REQ_STEP, $urandom_range(0, CMAX), $urandom_range(0, CMAX),
				$urandom_range(0, CMAX), $urandom_range(0, CMAX),
				COLOR_BITS'($urandom));
		end
	endtask

	function automatic int near_coord(input int c);
		int d;
		int n;
		d = $urandom_range(0, 32) - 16;
		n = c + d;
		if (n < 0 || n > CMAX) begin
			n = c - d;
		end
		return n;
	endfunction

	task automatic random_line();
		int  x0;
		int  y0;
		int  x1;
		int  y1;
		int  adx;
		int  ady;
		int  major;
		int  steps;
		logic far;
		x0  = $urandom_range(0, CMAX);
		y0  = $urandom_range(0, CMAX);
		far = $urandom_range(0, 24) == 0;
		if (far) begin
			x1 = $urandom_range(0, CMAX);
			y1 = $urandom_range(0, CMAX);
		end else begin
			x1 = near_coord(x0);
			y1 = near_coord(y0);
		end
		offer(REQ_START, x0, y0, x1, y1, COLOR_BITS'($urandom));
		adx   = (x1 > x0) ? x1 - x0 : x0 - x1;
		ady   = (y1 > y0) ? y1 - y0 : y0 - y1;
		major = (adx > ady) ? adx : ady;
		steps = major;
		if (far && $urandom_range(0, 3) != 0) begin
			steps = $urandom_range(0, 40);
			if (steps > major) begin
				steps = major;
			end
		end else if ($urandom_range(0, 7) == 0) begin
			steps = $urandom_range(0, major);
		end
		step_line(steps);
		line_items += 1 + steps;
		if (steps == major && $urandom_range(0, 3) == 0) begin
			step_line(1);
		end
	endtask

	initial begin
		int left;
		left = IDLE_LIMIT;
		while (idle_cycles < left) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int   n;
		logic do_hold;
		@(negedge clk);
		forever begin
			do_hold = hold_req;
			if (do_hold) begin
				hold_req = 1'b0;
				n        = HOLD_LEN;
			end else begin
				n = calm ? 0 : $urandom_range(0, 3);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: idle steps, degenerate lines, extremes, a tie, a
		// steep line and a start that cuts a line short.
		step_line(1);
		offer(REQ_START, 0, 0, 0, 0, 24'h000000);
		step_line(1);
		offer(REQ_START, 0, 0, CMAX, CMAX, 24'hFFFFFF);
		step_line(2);
		offer(REQ_START, 0, 0, 2, 1, 24'h123456);
		step_line(2);
		offer(REQ_START, CMAX, CMAX, 0, 0, 24'hAAAAAA);
		step_line(1);
		offer(REQ_START, 0, CMAX, CMAX, 0, 24'h555555);
		step_line(1);
		offer(REQ_START, 10, 10, 11, 14, 24'h0F0F0F);
		step_line(5);
		offer(REQ_START, CMAX, CMAX, CMAX, CMAX, 24'hFFFFFF);
		calm = 1'b1;
		offer(REQ_START, 20, 30, 15, 28, 24'hF0F0F0);
		step_line(5);
		calm = 1'b0;

		while (line_items < 1100) begin
			if ($urandom_range(0, 5) == 0) begin
				calm = !calm;
			end
			if (line_items > 500 && !hold_issued) begin
				hold_req    = 1'b1;
				hold_issued = 1'b1;
			end
			if ($urandom_range(0, 9) == 0) begin
				offer(1'($urandom_range(0, 1)), $urandom_range(0, CMAX),
					$urandom_range(0, CMAX), $urandom_range(0, CMAX),
					$urandom_range(0, CMAX), COLOR_BITS'($urandom));
			end else begin
				random_line();
			end
		end
		in_valid <= 1'b0;

		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/mlr_pkg.sv
rtl/mlr_setup.sv
rtl/mlr_core.sv
rtl/midpoint_line_rasterizer_unit.sv
verif/mlr_pixel_checker.sv
verif/tb_midpoint_line_rasterizer_unit.sv
